// ----- sv/eps_pkg.sv -----
// Shared types and constants for the encoder period speed estimator.
package eps_pkg;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EDGE,
      ST_IDLE_CNT,
      ST_STRETCH,
      ST_CHECK,
      ST_DIV_RATE,
      ST_RESULT
   } state_type;

   localparam int unsigned TimeWidth  = 32;
   localparam int unsigned IdleWidth  = 9;
   localparam int unsigned CsrWidth   = 8;
   localparam int unsigned SpeedWidth = 26;
   localparam int unsigned MagWidth   = 25;
   localparam int unsigned StepWidth  = 5;

   localparam logic [TimeWidth-1:0] SpeedScale = 32'd100000000;
   localparam logic [TimeWidth-1:0] SpeedDiv   = 32'd3;
   localparam logic [IdleWidth-1:0] IdleMax    = 9'd511;
   localparam logic [StepWidth-1:0] StepLast   = 5'd31;

   localparam logic [CsrWidth-1:0] TimeoutReset  = 8'd100;
   localparam logic [CsrWidth-1:0] SlowIdleReset = 8'd2;

   localparam logic [CsrWidth-1:0] CsrTimeoutTicks  = 8'd0;
   localparam logic [CsrWidth-1:0] CsrSlowIdleTicks = 8'd1;

   localparam logic FuncEdge = 1'b0;
   localparam logic FuncTick = 1'b1;

   localparam logic signed [1:0] DirFwd  = 2'sd1;
   localparam logic signed [1:0] DirRev  = -2'sd1;
   localparam logic signed [1:0] DirStop = 2'sd0;

endpackage

// ----- sv/encoder_period_speed_estimator.sv -----
// Encoder edge-period speed estimator with a serial divider.
// Edge word: accepted, state updated in the following cycle, then ready again.
// Tick word: result word valid after 3 control steps, one 32-step run of the restoring divider
// on 100000000 / (3 * period) and one output step; the divider run is skipped when stopped or
// the period is zero. Next word accepted in the cycle after the result is registered. One word
// in flight at a time; the result register lets the next word enter while it waits. Synchronous
// active-high reset clears control state but not the data registers; registers return to 100 and 2.
module encoder_period_speed_estimator (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic                                   req_func,
   input  logic                                   req_a_level,
   input  logic                                   req_b_level,
   input  logic [eps_pkg::TimeWidth-1:0]          req_time_us,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [eps_pkg::SpeedWidth-1:0]  rsp_speed,
   output logic signed [1:0]                      rsp_dir_out,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [eps_pkg::CsrWidth-1:0]           csr_index,
   input  logic [eps_pkg::CsrWidth-1:0]           csr_wdata
);

   eps_pkg::state_type state_ff, state_in;

   logic [eps_pkg::CsrWidth-1:0]   timeout_ff;
   logic [eps_pkg::CsrWidth-1:0]   slow_idle_ff;

   logic                           func_ff;
   logic                           a_ff;
   logic                           b_ff;
   logic [eps_pkg::TimeWidth-1:0]  time_ff;

   logic [eps_pkg::TimeWidth-1:0]  prev_edge_ff;
   logic [eps_pkg::TimeWidth-1:0]  cur_edge_ff;
   logic [eps_pkg::TimeWidth-1:0]  period_ff;
   logic [eps_pkg::TimeWidth-1:0]  seen_edge_ff;
   logic [eps_pkg::IdleWidth-1:0]  idle_ff;
   logic signed [1:0]              dir_ff;

   logic [eps_pkg::TimeWidth-1:0]  div_rem_ff;
   logic [eps_pkg::TimeWidth-1:0]  div_quo_ff;
   logic [eps_pkg::TimeWidth+1:0]  div_dvs_ff;
   logic [eps_pkg::StepWidth-1:0]  div_cnt_ff;
   logic                           zero_ff;

   logic                                  rsp_valid_ff;
   logic signed [eps_pkg::SpeedWidth-1:0] rsp_speed_ff;
   logic signed [1:0]                     rsp_dir_ff;

   logic                           req_fire;
   logic                           out_free;
   logic                           div_step;
   logic                           div_last;
   logic [eps_pkg::TimeWidth:0]    div_shift;
   logic [eps_pkg::TimeWidth+1:0]  div_diff;
   logic                           div_ge;
   logic [eps_pkg::TimeWidth-1:0]  div_rem_next;
   logic [eps_pkg::TimeWidth-1:0]  div_quo_next;
   logic [eps_pkg::IdleWidth-1:0]  idle_next;
   logic [eps_pkg::TimeWidth-1:0]  since;
   logic [eps_pkg::TimeWidth-1:0]  last;
   logic [eps_pkg::MagWidth-1:0]   mag;
   logic signed [eps_pkg::SpeedWidth-1:0] mag_signed;

   assign req_fire = req_valid && req_ready;
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign div_last = (div_cnt_ff == eps_pkg::StepLast);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         eps_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = (req_func == eps_pkg::FuncEdge) ? eps_pkg::ST_EDGE
                                                          : eps_pkg::ST_IDLE_CNT;
            end
         end
         eps_pkg::ST_EDGE:     state_in = eps_pkg::ST_IDLE;
         eps_pkg::ST_IDLE_CNT: state_in = eps_pkg::ST_STRETCH;
         eps_pkg::ST_STRETCH:  state_in = eps_pkg::ST_CHECK;
         eps_pkg::ST_CHECK: begin
            if (dir_ff != eps_pkg::DirStop && period_ff != '0) begin
               state_in = eps_pkg::ST_DIV_RATE;
            end else begin
               state_in = eps_pkg::ST_RESULT;
            end
         end
         eps_pkg::ST_DIV_RATE: begin
            if (div_last) begin
               state_in = eps_pkg::ST_RESULT;
            end
         end
         eps_pkg::ST_RESULT: begin
            if (out_free) begin
               state_in = eps_pkg::ST_IDLE;
            end
         end
         default: state_in = eps_pkg::ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      req_ready = 1'b0;
      div_step  = 1'b0;
      unique case (state_ff)
         eps_pkg::ST_IDLE:      req_ready = 1'b1;
         eps_pkg::ST_DIV_RATE:  div_step  = 1'b1;
         default: begin
            req_ready = 1'b0;
            div_step  = 1'b0;
         end
      endcase
   end

   assign csr_ready = 1'b1;

   // restoring divider, one quotient bit a cycle
   assign div_shift    = {div_rem_ff, div_quo_ff[eps_pkg::TimeWidth-1]};
   assign div_diff     = {1'b0, div_shift} - div_dvs_ff;
   assign div_ge       = ({1'b0, div_shift} >= div_dvs_ff);
   assign div_rem_next = div_ge ? div_diff[eps_pkg::TimeWidth-1:0]
                                : div_shift[eps_pkg::TimeWidth-1:0];
   assign div_quo_next = {div_quo_ff[eps_pkg::TimeWidth-2:0], div_ge};

   assign idle_next = (seen_edge_ff != cur_edge_ff) ? '0 :
                      (idle_ff < eps_pkg::IdleMax)  ? idle_ff + 1'b1 : idle_ff;

   assign since = time_ff - cur_edge_ff;
   assign last  = cur_edge_ff - prev_edge_ff;

   assign mag        = zero_ff ? '0 : div_quo_ff[eps_pkg::MagWidth-1:0];
   assign mag_signed = $signed({1'b0, mag});

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= eps_pkg::ST_IDLE;
         timeout_ff   <= eps_pkg::TimeoutReset;
         slow_idle_ff <= eps_pkg::SlowIdleReset;
         prev_edge_ff <= '0;
         cur_edge_ff  <= '0;
         period_ff    <= '0;
         seen_edge_ff <= '0;
         idle_ff      <= '0;
         dir_ff       <= eps_pkg::DirStop;
         div_cnt_ff   <= '0;
         zero_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;

         if (csr_valid && csr_ready) begin
            if (csr_index == eps_pkg::CsrTimeoutTicks) begin
               timeout_ff <= csr_wdata;
            end else if (csr_index == eps_pkg::CsrSlowIdleTicks) begin
               slow_idle_ff <= csr_wdata;
            end
         end

         if (state_ff == eps_pkg::ST_RESULT && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            eps_pkg::ST_EDGE: begin
               dir_ff       <= (a_ff == b_ff) ? eps_pkg::DirFwd : eps_pkg::DirRev;
               prev_edge_ff <= cur_edge_ff;
               cur_edge_ff  <= time_ff;
               period_ff    <= time_ff - cur_edge_ff;
            end
            eps_pkg::ST_IDLE_CNT: begin
               seen_edge_ff <= cur_edge_ff;
               if (idle_next > {1'b0, timeout_ff}) begin
                  idle_ff <= '0;
                  dir_ff  <= eps_pkg::DirStop;
               end else begin
                  idle_ff <= idle_next;
               end
            end
            eps_pkg::ST_STRETCH: begin
               if (dir_ff != eps_pkg::DirStop && since > last
                   && idle_ff > {1'b0, slow_idle_ff}) begin
                  period_ff <= time_ff - prev_edge_ff;
               end
            end
            eps_pkg::ST_CHECK: begin
               div_cnt_ff <= '0;
               zero_ff    <= !(dir_ff != eps_pkg::DirStop && period_ff != '0);
            end
            eps_pkg::ST_DIV_RATE: begin
               div_cnt_ff <= div_cnt_ff + 1'b1;
            end
            default: begin
               div_cnt_ff <= div_cnt_ff;
            end
         endcase
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (req_fire) begin
         func_ff <= req_func;
         a_ff    <= req_a_level;
         b_ff    <= req_b_level;
         time_ff <= req_time_us;
      end

      if (state_ff == eps_pkg::ST_CHECK) begin
         div_rem_ff <= '0;
         div_quo_ff <= eps_pkg::SpeedScale;
         div_dvs_ff <= {1'b0, period_ff, 1'b0} + {2'b00, period_ff};
      end else if (div_step) begin
         div_rem_ff <= div_rem_next;
         div_quo_ff <= div_quo_next;
      end

      if (state_ff == eps_pkg::ST_RESULT && out_free) begin
         rsp_speed_ff <= (dir_ff == eps_pkg::DirRev) ? -mag_signed : mag_signed;
         rsp_dir_ff   <= dir_ff;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_speed   = rsp_speed_ff;
   assign rsp_dir_out = rsp_dir_ff;

   a_dir_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_dir_out != -2'sd2))
      else $error("result direction out of range");

   a_stop_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_dir_out == eps_pkg::DirStop) |-> (rsp_speed == '0))
      else $error("speed nonzero while stopped");

   a_tick_busy: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_func == eps_pkg::FuncTick) |=> !req_ready)
      else $error("accepted a word while a tick is in progress");

   a_idle_bound: assert property (@(posedge clock) disable iff (reset)
      idle_ff <= 9'd256)
      else $error("idle count past its bound");

   a_func_kept: assert property (@(posedge clock) disable iff (reset)
      (state_ff == eps_pkg::ST_EDGE) |-> (func_ff == eps_pkg::FuncEdge))
      else $error("edge update for a tick word");

endmodule

// ----- dv/tb_top.sv -----
// Self-checking testbench for the encoder period speed estimator.
module tb_top;

   typedef struct {
      logic signed [eps_pkg::SpeedWidth-1:0] speed;
      logic signed [1:0]                     dir;
   } speed_reading_type;

   typedef struct {
      logic                          func;
      logic                          a_level;
      logic                          b_level;
      logic [eps_pkg::TimeWidth-1:0] time_us;
      bit                            pinned;
      speed_reading_type             reading;
   } stim_row_type;

   localparam int unsigned DirectedRows = 18;
   localparam int unsigned PhaseCount   = 9;
   localparam int unsigned PhaseWords   = 125;
   localparam int unsigned SettleCycles = 80;
   localparam int unsigned ChokeCycles  = 500;
   localparam int unsigned ReportLimit  = 10;
   localparam logic [eps_pkg::CsrWidth-1:0] CsrNoReg = 8'hFF;

   logic                                  clock;
   logic                                  reset;
   logic                                  req_valid;
   logic                                  req_ready;
   logic                                  req_func;
   logic                                  req_a_level;
   logic                                  req_b_level;
   logic [eps_pkg::TimeWidth-1:0]         req_time_us;
   logic                                  rsp_valid;
   logic                                  rsp_ready;
   logic signed [eps_pkg::SpeedWidth-1:0] rsp_speed;
   logic signed [1:0]                     rsp_dir_out;
   logic                                  csr_valid;
   logic                                  csr_ready;
   logic [eps_pkg::CsrWidth-1:0]          csr_index;
   logic [eps_pkg::CsrWidth-1:0]          csr_wdata;

   // own copy of the estimator state and registers
   logic [eps_pkg::TimeWidth-1:0] last_edge_t;
   logic [eps_pkg::TimeWidth-1:0] this_edge_t;
   logic [eps_pkg::TimeWidth-1:0] period_us;
   logic [eps_pkg::TimeWidth-1:0] noted_edge_t;
   logic [eps_pkg::IdleWidth-1:0] idle_ticks;
   logic signed [1:0]             heading;
   logic [eps_pkg::CsrWidth-1:0]  timeout_cfg;
   logic [eps_pkg::CsrWidth-1:0]  slow_cfg;

   speed_reading_type speed_due[$];
   speed_reading_type no_pin;
   stim_row_type      plan[DirectedRows];

   bit          steady;
   bit          choke_rsp;
   int unsigned mismatches = 0;
   int unsigned results_seen = 0;
   int unsigned edges_sent;
   int unsigned ticks_sent;
   int unsigned timeouts_hit;
   int unsigned stretches_hit;

   encoder_period_speed_estimator DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_func    (req_func),
      .req_a_level (req_a_level),
      .req_b_level (req_b_level),
      .req_time_us (req_time_us),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_speed   (rsp_speed),
      .rsp_dir_out (rsp_dir_out),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   function automatic int unsigned pause_len();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 75) return $urandom_range(1, 3);
      if (roll < 95) return $urandom_range(4, 12);
      return $urandom_range(30, 100);
   endfunction

   function automatic bit forecast(input logic func, input logic a, input logic b,
                                   input logic [eps_pkg::TimeWidth-1:0] t,
                                   output speed_reading_type r);
      logic [eps_pkg::TimeWidth-1:0] since;
      logic [eps_pkg::TimeWidth-1:0] span;
      logic [eps_pkg::TimeWidth-1:0] quot;
      r.speed = '0;
      r.dir = eps_pkg::DirStop;
      if (func == eps_pkg::FuncEdge) begin
         heading = (a == b) ? eps_pkg::DirFwd : eps_pkg::DirRev;
         last_edge_t = this_edge_t;
         this_edge_t = t;
         period_us = t - last_edge_t;
         return 1'b0;
      end
      if (noted_edge_t == this_edge_t) begin
         if (idle_ticks < eps_pkg::IdleMax) idle_ticks = idle_ticks + 1'b1;
      end else begin
         noted_edge_t = this_edge_t;
         idle_ticks = '0;
      end
      if (idle_ticks > {1'b0, timeout_cfg}) begin
         idle_ticks = '0;
         heading = eps_pkg::DirStop;
         timeouts_hit++;
      end
      quot = '0;
      if (heading != eps_pkg::DirStop) begin
         since = t - this_edge_t;
         span = this_edge_t - last_edge_t;
         if (since > span && idle_ticks > {1'b0, slow_cfg}) begin
            period_us = t - last_edge_t;
            stretches_hit++;
         end
         if (period_us != '0) quot = (eps_pkg::SpeedScale / period_us) / eps_pkg::SpeedDiv;
      end
      r.speed = {1'b0, quot[eps_pkg::MagWidth-1:0]};
      if (heading == eps_pkg::DirRev) r.speed = -r.speed;
      r.dir = heading;
      return 1'b1;
   endfunction

   task automatic send_word(input logic func, input logic a, input logic b,
                            input logic [eps_pkg::TimeWidth-1:0] t, input bit pinned,
                            input speed_reading_type pin);
      speed_reading_type r;
      int unsigned gap;
      req_valid <= 1'b1;
      req_func <= func;
      req_a_level <= a;
      req_b_level <= b;
      req_time_us <= t;
      do @(posedge clock); while (!req_ready);
      if (forecast(func, a, b, t, r)) begin
         if (pinned) speed_due.push_back(pin);
         else speed_due.push_back(r);
         ticks_sent++;
      end else begin
         edges_sent++;
      end
      gap = (!steady && $urandom_range(0, 9) < 4) ? pause_len() : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic write_csr(input logic [eps_pkg::CsrWidth-1:0] idx,
                            input logic [eps_pkg::CsrWidth-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      if (idx == eps_pkg::CsrTimeoutTicks) timeout_cfg = val;
      else if (idx == eps_pkg::CsrSlowIdleTicks) slow_cfg = val;
   endtask

   task automatic drain();
      while (speed_due.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic run_phase(input int unsigned budget);
      int unsigned n;
      int unsigned k;
      int unsigned len;
      int unsigned stride;
      int unsigned roll;
      logic [eps_pkg::TimeWidth-1:0] now;
      logic fwd;
      logic a;
      n = 0;
      now = $urandom();
      fwd = 1'b1;
      while (n < budget) begin
         roll = $urandom_range(0, 99);
         if (roll < 60) begin
            // shaft turning: edges and ticks interleaved at a chosen pace
            roll = $urandom_range(0, 99);
            if (roll < 15) stride = $urandom_range(1, 8);
            else if (roll < 85) stride = $urandom_range(50, 3000);
            else stride = $urandom_range(3000, 1 << 24);
            len = $urandom_range(3, 12);
            for (k = 0; k < len; k++) begin
               now += $urandom_range(1, 2 * stride);
               if ($urandom_range(0, 19) == 0) fwd = ~fwd;
               a = 1'($urandom_range(0, 1));
               if ($urandom_range(0, 1) == 0)
                  send_word(eps_pkg::FuncEdge, a, fwd ? a : ~a, now, 1'b0, no_pin);
               else
                  send_word(eps_pkg::FuncTick, a, 1'($urandom_range(0, 1)), now, 1'b0,
                            no_pin);
            end
         end else if (roll < 80) begin
            // shaft halted: ticks only, often long enough to time out
            stride = $urandom_range(100, 2000);
            if ($urandom_range(0, 1) == 0) len = $urandom_range(1, 8);
            else len = timeout_cfg + $urandom_range(1, 4);
            for (k = 0; k < len; k++) begin
               now += stride + $urandom_range(0, 15);
               send_word(eps_pkg::FuncTick, 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)), now, 1'b0, no_pin);
            end
         end else if (roll < 90) begin
            len = 3;
            a = 1'($urandom_range(0, 1));
            send_word(eps_pkg::FuncEdge, a, 1'($urandom_range(0, 1)), now, 1'b0, no_pin);
            send_word(eps_pkg::FuncEdge, ~a, 1'($urandom_range(0, 1)), now, 1'b0, no_pin);
            now += $urandom_range(0, 3);
            send_word(eps_pkg::FuncTick, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      now, 1'b0, no_pin);
         end else begin
            len = $urandom_range(1, 4);
            for (k = 0; k < len; k++)
               send_word(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)), $urandom(), 1'b0, no_pin);
         end
         n += len;
      end
   endtask

   initial begin : rsp_side
      int unsigned stall;
      int unsigned choke;
      bit          choke_done;
      rsp_ready = 1'b0;
      stall = 0;
      choke = 0;
      choke_done = 1'b0;
      forever begin
         @(posedge clock);
         if (choke_rsp && !choke_done) begin
            choke_done = 1'b1;
            choke = ChokeCycles;
         end
         if (choke != 0) begin
            rsp_ready <= 1'b0;
            choke--;
         end else if (stall != 0) begin
            rsp_ready <= 1'b0;
            stall--;
         end else begin
            rsp_ready <= 1'b1;
            if (!steady && $urandom_range(0, 5) == 0) stall = pause_len();
         end
      end
   end

   always @(posedge clock) begin : check_reading
      speed_reading_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (speed_due.size() == 0) begin
            mismatches++;
            if (mismatches <= ReportLimit)
               $display("unexpected result word %0d: speed %0d dir %0d",
                        results_seen, rsp_speed, rsp_dir_out);
         end else begin
            want = speed_due.pop_front();
            if (rsp_speed !== want.speed || rsp_dir_out !== want.dir) begin
               mismatches++;
               if (mismatches <= ReportLimit)
                  $display("result word %0d: expected speed %0d dir %0d, got speed %0d dir %0d",
                           results_seen, want.speed, want.dir, rsp_speed, rsp_dir_out);
            end
         end
      end
   end

   initial begin : watchdog
      #36000000;
      $display("FAIL");
      $finish;
   end

   initial begin : stimulus
      int unsigned i;
      int unsigned p;
      logic [eps_pkg::CsrWidth-1:0] t_cfg;
      logic [eps_pkg::CsrWidth-1:0] s_cfg;
      reset = 1'b1;
      req_valid = 1'b0;
      req_func = eps_pkg::FuncEdge;
      req_a_level = 1'b0;
      req_b_level = 1'b0;
      req_time_us = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      steady = 1'b0;
      choke_rsp = 1'b0;
      edges_sent = 0;
      ticks_sent = 0;
      timeouts_hit = 0;
      stretches_hit = 0;
      no_pin = '{'0, eps_pkg::DirStop};
      last_edge_t = '0;
      this_edge_t = '0;
      period_us = '0;
      noted_edge_t = '0;
      idle_ticks = '0;
      heading = eps_pkg::DirStop;
      timeout_cfg = eps_pkg::TimeoutReset;
      slow_cfg = eps_pkg::SlowIdleReset;

      plan[0]  = '{eps_pkg::FuncTick, 1'b0, 1'b0, 32'd0,         1'b1,
                   '{26'sd0, eps_pkg::DirStop}};
      plan[1]  = '{eps_pkg::FuncEdge, 1'b1, 1'b1, 32'd1000,      1'b0,
                   '{26'sd0, eps_pkg::DirStop}};
      plan[2]  = '{eps_pkg::FuncTick, 1'b0, 1'b0, 32'd1500,      1'b1,
                   '{26'sd33333, eps_pkg::DirFwd}};
      plan[3]  = '{eps_pkg::FuncEdge, 1'b0, 1'b1, 32'd1001,      1'b0,
                   '{26'sd0, eps_pkg::DirStop}};
      plan[4]  = '{eps_pkg::FuncTick, 1'b1, 1'b1, 32'd1001,      1'b1,
                   '{-26'sd33333333, eps_pkg::DirRev}};
      plan[5]  = '{eps_pkg::FuncEdge, 1'b1, 1'b1, 32'd1001,      1'b0,
                   '{26'sd0, eps_pkg::DirStop}};
      plan[6]  = '{eps_pkg::FuncTick, 1'b0, 1'b1, 32'd1002,      1'b1,
                   '{26'sd0, eps_pkg::DirFwd}};
      plan[7]  = '{eps_pkg::FuncTick, 1'b1, 1'b0, 32'd1003,      1'b0,
                   '{26'sd0, eps_pkg::DirStop}};
      plan[8]  = '{eps_pkg::FuncTick, 1'b0, 1'b0, 32'd1004,      1'b0,
                   '{26'sd0, eps_pkg::DirStop}};
      plan[9]  = '{eps_pkg::FuncEdge, 1'b1, 1'b0, 32'hFFFF_FF00, 1'b0,
                   '{26'sd0, eps_pkg::DirStop}};
      plan[10] = '{eps_pkg::FuncEdge, 1'b0, 1'b0, 32'h0000_0100, 1'b0,
                   '{26'sd0, eps_pkg::DirStop}};
      plan[11] = '{eps_pkg::FuncTick, 1'b1, 1'b1, 32'h0000_0180, 1'b0,
                   '{26'sd0, eps_pkg::DirStop}};
      plan[12] = '{eps_pkg::FuncEdge, 1'b0, 1'b1, 32'hFFFF_FFFF, 1'b0,
                   '{26'sd0, eps_pkg::DirStop}};
      plan[13] = '{eps_pkg::FuncTick, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b0,
                   '{26'sd0, eps_pkg::DirStop}};
      plan[14] = '{eps_pkg::FuncTick, 1'b0, 1'b0, 32'd0,         1'b0,
                   '{26'sd0, eps_pkg::DirStop}};
      plan[15] = '{eps_pkg::FuncEdge, 1'b1, 1'b1, 32'd1,         1'b0,
                   '{26'sd0, eps_pkg::DirStop}};
      plan[16] = '{eps_pkg::FuncEdge, 1'b1, 1'b1, 32'd0,         1'b0,
                   '{26'sd0, eps_pkg::DirStop}};
      plan[17] = '{eps_pkg::FuncTick, 1'b0, 1'b0, 32'd0,         1'b1,
                   '{26'sd0, eps_pkg::DirFwd}};

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      for (i = 0; i < DirectedRows; i++)
         send_word(plan[i].func, plan[i].a_level, plan[i].b_level, plan[i].time_us,
                   plan[i].pinned, plan[i].reading);
      req_valid <= 1'b0;

      for (p = 0; p < PhaseCount; p++) begin
         drain();
         unique case (p)
            0: begin t_cfg = 8'd1;   s_cfg = 8'd0;   end
            1: begin t_cfg = 8'd0;   s_cfg = 8'd0;   end
            2: begin t_cfg = 8'd255; s_cfg = 8'd255; end
            3: begin t_cfg = 8'd3;   s_cfg = 8'd1;   end
            4: begin t_cfg = 8'd255; s_cfg = 8'd0;   end
            5: begin t_cfg = 8'd20;  s_cfg = 8'd5;   end
            7: begin
               t_cfg = 8'($urandom_range(1, 12));
               s_cfg = 8'($urandom_range(0, 6));
            end
            default: begin
               t_cfg = 8'($urandom_range(0, 255));
               s_cfg = 8'($urandom_range(0, 255));
            end
         endcase
         write_csr(eps_pkg::CsrTimeoutTicks, t_cfg);
         write_csr(eps_pkg::CsrSlowIdleTicks, s_cfg);
         if (p == 0) write_csr(CsrNoReg, 8'($urandom_range(0, 255)));
         csr_valid <= 1'b0;
         steady = (p == 5);
         // hold the result side off while words keep coming
         if (p == 3) choke_rsp = 1'b1;
         run_phase(PhaseWords);
         req_valid <= 1'b0;
      end
      drain();

      $display("covered %0d edge words and %0d tick words over %0d register settings",
               edges_sent, ticks_sent, PhaseCount + 1);
      $display("%0d direction timeouts, %0d period stretches, %0d results checked, %0d bad",
               timeouts_hit, stretches_hit, results_seen, mismatches);
      if (mismatches == 0 && speed_due.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
